>>> rtl/multichannel_pid_step_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel PID step block
// Shared forms for same-cycle and next-cycle implications under reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PID_STEP_TOP_DEFINES_SVH
`define MULTICHANNEL_PID_STEP_TOP_DEFINES_SVH

// The consequent must hold at the same edge as the antecedent.
`define MPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define MPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Widths, register indexes, sequencer types and saturation helpers.
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int CHAN_W       = 3;
  localparam int Q_W          = 32;
  localparam int FRAC_W       = 16;
  localparam int TS_W         = 17;
  localparam int ITS_W        = 31;
  localparam int MUL_W        = Q_W + 1;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int ACC_W        = Q_W + 2;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;

  localparam logic [TS_W-1:0]  TS_RESET  = 17'd6554;
  localparam logic [ITS_W-1:0] ITS_RESET = 31'd655360;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TIME_STEP = 8'd1;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_I,
    ST_MUL_D,
    ST_MUL_P,
    ST_MUL_KI,
    ST_MUL_KD,
    ST_DONE
  } pid_state_t;

  typedef enum logic [2:0] {
    MUL_ERR_TS,
    MUL_DIFF_INV,
    MUL_KP_ERR,
    MUL_KI_INT,
    MUL_KD_DER
  } mul_op_t;

  typedef struct packed {
    logic in_valid;
    logic out_space;
  } seq_stat_t;

  typedef struct packed {
    logic    in_ready;
    logic    ld_error;
    logic    ld_diff;
    logic    ld_integral;
    logic    ld_deriv;
    logic    acc_init;
    logic    acc_add;
    logic    mul_issue;
    mul_op_t mul_op;
    logic    finish;
  } seq_ctrl_t;

  // Saturate a 33-bit two-operand sum or difference to 32 bits.
  function automatic logic signed [Q_W-1:0] sat_sum(input logic signed [Q_W:0] s);
    logic signed [Q_W-1:0] r;
    if (s[Q_W] != s[Q_W-1]) begin
      r = s[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      r = s[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [Q_W:0] sext1(input logic signed [Q_W-1:0] v);
    return {v[Q_W-1], v};
  endfunction

endpackage

>>> rtl/mps_if.sv
// ----------------------------------------------------------------------------
// mps_if
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface mps_in_if;
  import mps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CHAN_W-1:0]     channel;
  logic signed [Q_W-1:0] target;
  logic signed [Q_W-1:0] measured;
  logic signed [Q_W-1:0] gain_p;
  logic signed [Q_W-1:0] gain_i;
  logic signed [Q_W-1:0] gain_d;

  modport source (output valid, channel, target, measured, gain_p, gain_i, gain_d,
                  input ready);
  modport sink (input valid, channel, target, measured, gain_p, gain_i, gain_d,
                output ready);
endinterface

interface mps_out_if;
  import mps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CHAN_W-1:0]     out_channel;
  logic signed [Q_W-1:0] drive;

  modport source (output valid, out_channel, drive, input ready);
  modport sink (input valid, out_channel, drive, output ready);
endinterface

interface mps_cfg_if;
  import mps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/mps_mac.sv
// ----------------------------------------------------------------------------
// mps_mac
// Shared Q16.16 multiplier: registered product, floor shift and saturation.
// ----------------------------------------------------------------------------
module mps_mac (
  input  logic                           clk,
  input  logic                           issue,
  input  logic signed [mps_pkg::MUL_W-1:0] op_a,
  input  logic signed [mps_pkg::MUL_W-1:0] op_b,
  output logic signed [mps_pkg::Q_W-1:0]   q
);
  import mps_pkg::*;

  localparam int SH_W = PROD_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_r;
  logic        [SH_W-1:0]   sh;
  logic        [SH_W-Q_W:0] hi;

  // The product register holds until the next issue, so a result can be
  // consumed in any later cycle.
  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= op_a * op_b;
    end
  end

  // Dropping the low fraction bits of a two's complement word is a floor.
  assign sh = prod_r[PROD_W-1:FRAC_W];
  assign hi = sh[SH_W-1:Q_W-1];

  always_comb begin
    if ((&hi) || (~|hi)) begin
      q = sh[Q_W-1:0];
    end else begin
      q = sh[SH_W-1] ? Q_MIN : Q_MAX;
    end
  end

endmodule

>>> rtl/mps_state_mem.sv
// ----------------------------------------------------------------------------
// mps_state_mem
// Per-channel integral and last error store with registered read.
// ----------------------------------------------------------------------------
module mps_state_mem #(
  parameter int DEPTH  = mps_pkg::CHANNELS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic signed [mps_pkg::Q_W-1:0] rd_integral,
  output logic signed [mps_pkg::Q_W-1:0] rd_error,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic signed [mps_pkg::Q_W-1:0] wr_integral,
  input  logic signed [mps_pkg::Q_W-1:0] wr_error
);
  import mps_pkg::*;

  logic [2*Q_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [2*Q_W-1:0] rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_integral, wr_error};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_integral = rd_valid_r ? rd_data_r[2*Q_W-1:Q_W] : '0;
  assign rd_error    = rd_valid_r ? rd_data_r[Q_W-1:0]     : '0;

endmodule

>>> rtl/mps_seq.sv
// ----------------------------------------------------------------------------
// mps_seq
// Sequencer that steps one item through the shared multiplier.
// ----------------------------------------------------------------------------
module mps_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  mps_pkg::seq_stat_t stat,
  output mps_pkg::seq_ctrl_t ctrl
);
  import mps_pkg::*;

  pid_state_t state_r;
  pid_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (stat.in_valid) state_nxt = ST_ERR;
      ST_ERR:    state_nxt = ST_MUL_I;
      ST_MUL_I:  state_nxt = ST_MUL_D;
      ST_MUL_D:  state_nxt = ST_MUL_P;
      ST_MUL_P:  state_nxt = ST_MUL_KI;
      ST_MUL_KI: state_nxt = ST_MUL_KD;
      ST_MUL_KD: state_nxt = ST_DONE;
      ST_DONE:   if (stat.out_space) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Each multiply state after the first also consumes the product issued one
  // state earlier; the last product is consumed in the done state.
  always_comb begin
    ctrl        = '0;
    ctrl.mul_op = MUL_ERR_TS;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
      end
      ST_ERR: begin
        ctrl.ld_error = 1'b1;
      end
      ST_MUL_I: begin
        ctrl.mul_issue = 1'b1;
        ctrl.mul_op    = MUL_ERR_TS;
        ctrl.ld_diff   = 1'b1;
      end
      ST_MUL_D: begin
        ctrl.mul_issue   = 1'b1;
        ctrl.mul_op      = MUL_DIFF_INV;
        ctrl.ld_integral = 1'b1;
      end
      ST_MUL_P: begin
        ctrl.mul_issue = 1'b1;
        ctrl.mul_op    = MUL_KP_ERR;
        ctrl.ld_deriv  = 1'b1;
      end
      ST_MUL_KI: begin
        ctrl.mul_issue = 1'b1;
        ctrl.mul_op    = MUL_KI_INT;
        ctrl.acc_init  = 1'b1;
      end
      ST_MUL_KD: begin
        ctrl.mul_issue = 1'b1;
        ctrl.mul_op    = MUL_KD_DER;
        ctrl.acc_add   = 1'b1;
      end
      ST_DONE: begin
        ctrl.finish = stat.out_space;
      end
      default: begin
        ctrl.in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/multichannel_pid_step_top.sv
// ----------------------------------------------------------------------------
// multichannel_pid_step_top
// Multichannel discrete PID step in signed Q16.16 with per-channel state.
// Each input beat steps from acceptance to a loaded result: accept and read
// the channel's stored integral and last error, form the error, five issues
// on the single 33x33 multiplier (error*dt, difference*1/dt and the three
// gain products, each consumed in the following state), and a final step
// that sums the drive value, writes the channel state back and loads the
// output register. A new beat is taken in the cycle after that, even while
// the previous result waits; the final step stalls only while the output
// register is still full. Channel numbers at or above CHANNELS use the state
// of channel modulo CHANNELS. Register writes are taken every cycle.
// ----------------------------------------------------------------------------
module multichannel_pid_step_top #(
  parameter int CHANNELS = mps_pkg::CHANNELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mps_in_if.sink       in_chan,
  mps_out_if.source    out_chan,
  mps_cfg_if.sink      cfg_chan
);
  import mps_pkg::*;

  localparam int SLOT_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CALC_W   = ($clog2(CHANNELS + 1) > CHAN_W) ? $clog2(CHANNELS + 1) : CHAN_W;
  localparam int SUB_STEPS = 2 ** CHAN_W;
  localparam logic [CALC_W-1:0] CH_LIM = CALC_W'(CHANNELS);

  // Configuration registers
  logic [TS_W-1:0]  ts_r;
  logic [ITS_W-1:0] its_r;

  // Item registers
  logic [CHAN_W-1:0]     chan_r;
  logic [SLOT_W-1:0]     slot_r;
  logic signed [Q_W-1:0] target_r;
  logic signed [Q_W-1:0] measured_r;
  logic signed [Q_W-1:0] kp_r;
  logic signed [Q_W-1:0] ki_r;
  logic signed [Q_W-1:0] kd_r;
  logic signed [Q_W-1:0] error_r;
  logic signed [Q_W-1:0] diff_r;
  logic signed [Q_W-1:0] integral_r;
  logic signed [Q_W-1:0] deriv_r;
  logic signed [ACC_W-1:0] acc_r;

  // Output register
  logic                  out_valid_r;
  logic [CHAN_W-1:0]     out_channel_r;
  logic signed [Q_W-1:0] drive_r;

  seq_stat_t stat;
  seq_ctrl_t ctrl;
  logic      in_accept;
  logic [CALC_W-1:0]     slot_calc;
  logic [SLOT_W-1:0]     slot;
  logic signed [Q_W-1:0] st_integral;
  logic signed [Q_W-1:0] st_error;
  logic signed [MUL_W-1:0] op_a;
  logic signed [MUL_W-1:0] op_b;
  logic signed [Q_W-1:0]   q;
  logic signed [ACC_W-1:0] q_ext;
  logic signed [ACC_W-1:0] total;
  logic signed [Q_W-1:0]   drive_sat;

  assign in_accept      = in_chan.valid && ctrl.in_ready;
  assign in_chan.ready  = ctrl.in_ready;
  assign stat.in_valid  = in_chan.valid;
  assign stat.out_space = !out_valid_r || out_chan.ready;

  mps_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Channel to slot by repeated subtraction; the channel field is narrow.
  always_comb begin
    slot_calc = CALC_W'(in_chan.channel);
    for (int k = 0; k < SUB_STEPS; k++) begin
      if (slot_calc >= CH_LIM) begin
        slot_calc = slot_calc - CH_LIM;
      end
    end
  end
  assign slot = slot_calc[SLOT_W-1:0];

  mps_state_mem #(
    .DEPTH  (CHANNELS),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (in_accept),
    .rd_addr     (slot),
    .rd_integral (st_integral),
    .rd_error    (st_error),
    .wr_en       (ctrl.finish),
    .wr_addr     (slot_r),
    .wr_integral (integral_r),
    .wr_error    (error_r)
  );

  // Operand selection for the shared multiplier
  always_comb begin
    case (ctrl.mul_op)
      MUL_ERR_TS: begin
        op_a = sext1(error_r);
        op_b = $signed({{(MUL_W-TS_W){1'b0}}, ts_r});
      end
      MUL_DIFF_INV: begin
        op_a = sext1(diff_r);
        op_b = $signed({{(MUL_W-ITS_W){1'b0}}, its_r});
      end
      MUL_KP_ERR: begin
        op_a = sext1(kp_r);
        op_b = sext1(error_r);
      end
      MUL_KI_INT: begin
        op_a = sext1(ki_r);
        op_b = sext1(integral_r);
      end
      MUL_KD_DER: begin
        op_a = sext1(kd_r);
        op_b = sext1(deriv_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  mps_mac u_mac (
    .clk   (clk),
    .issue (ctrl.mul_issue),
    .op_a  (op_a),
    .op_b  (op_b),
    .q     (q)
  );

  assign q_ext = {{(ACC_W-Q_W){q[Q_W-1]}}, q};
  assign total = acc_r + q_ext;

  always_comb begin
    if ((&total[ACC_W-1:Q_W-1]) || (~|total[ACC_W-1:Q_W-1])) begin
      drive_sat = total[Q_W-1:0];
    end else begin
      drive_sat = total[ACC_W-1] ? Q_MIN : Q_MAX;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      chan_r     <= in_chan.channel;
      slot_r     <= slot;
      target_r   <= in_chan.target;
      measured_r <= in_chan.measured;
      kp_r       <= in_chan.gain_p;
      ki_r       <= in_chan.gain_i;
      kd_r       <= in_chan.gain_d;
    end
    if (ctrl.ld_error) begin
      error_r <= sat_sum(sext1(target_r) - sext1(measured_r));
    end
    if (ctrl.ld_diff) begin
      diff_r <= sat_sum(sext1(error_r) - sext1(st_error));
    end
    if (ctrl.ld_integral) begin
      integral_r <= sat_sum(sext1(st_integral) + sext1(q));
    end
    if (ctrl.ld_deriv) begin
      deriv_r <= q;
    end
    if (ctrl.acc_init) begin
      acc_r <= q_ext;
    end else if (ctrl.acc_add) begin
      acc_r <= total;
    end
  end

  // Output register: holds a finished beat while the next item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_channel_r <= chan_r;
      drive_r       <= drive_sat;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_channel = out_channel_r;
  assign out_chan.drive       = drive_r;

  // Configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r  <= TS_RESET;
      its_r <= ITS_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_TIME_STEP:     ts_r  <= cfg_chan.data[TS_W-1:0];
        REG_INV_TIME_STEP: its_r <= cfg_chan.data[ITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/mps_checker.sv
// ----------------------------------------------------------------------------
// mps_checker
// Port-level checks on the PID step block, attached by bind.
// ----------------------------------------------------------------------------
`include "multichannel_pid_step_top_defines.svh"

module mps_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mps_pkg::CHAN_W-1:0]     out_channel,
  input logic signed [mps_pkg::Q_W-1:0] drive
);
  import mps_pkg::*;

  // A stalled result beat stays offered and unchanged.
  `MPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
  `MPS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(drive) && $stable(out_channel), "result beat changed while stalled")

  // The block works on one item at a time.
  `MPS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while an item is in progress")

  // A fresh result is loaded as the sequencer returns to accepting input.
  `MPS_ASSERT_SAME(a_result_frees_input, clk, rst_n, $rose(out_valid), in_ready, "result appeared while the block was busy")

endmodule

bind multichannel_pid_step_top mps_checker u_mps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_channel (out_chan.out_channel),
  .drive       (out_chan.drive)
);

>>> tb/sv/multichannel_pid_step_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_pid_step_top_test
// Self-checking bench for the multichannel PID step. A local Q16.16 predictor
// keeps its own per-channel integral and last error. Each accepted beat on the
// input channel is turned into an expected channel and drive value. Results
// are checked in order while both sides idle at random.
// ----------------------------------------------------------------------------
module multichannel_pid_step_top_test;
  import mps_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 225;

  localparam logic signed [Q_W-1:0] Q_ONE  = 32'sd65536;
  localparam logic signed [Q_W-1:0] Q_HALF = 32'sd32768;

  typedef struct {
    logic [CHAN_W-1:0]     channel;
    logic signed [Q_W-1:0] target;
    logic signed [Q_W-1:0] measured;
    logic signed [Q_W-1:0] gain_p;
    logic signed [Q_W-1:0] gain_i;
    logic signed [Q_W-1:0] gain_d;
  } pid_item_t;

  typedef struct {
    logic [CHAN_W-1:0]     channel;
    logic signed [Q_W-1:0] drive;
  } drive_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int          mismatch_count = 0;
  bit          steady = 1'b0;

  // Predictor copy of the registers and the per-channel state.
  logic [TS_W-1:0]       dt_reg;
  logic [ITS_W-1:0]      inv_dt_reg;
  logic signed [Q_W-1:0] integral_mem [CHANNELS_DEF];
  logic signed [Q_W-1:0] last_error_mem [CHANNELS_DEF];
  drive_result_t         drive_queue [$];

  mps_in_if  in_bus ();
  mps_out_if out_bus ();
  mps_cfg_if cfg_bus ();

  multichannel_pid_step_top #(
    .CHANNELS (CHANNELS_DEF)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [Q_W-1:0] sat_q(input longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[Q_W-1:0];
  endfunction

  // Q16.16 product: floor of the full product over 2^16, then saturated.
  function automatic logic signed [Q_W-1:0] q_mul(input longint a, input longint b);
    longint p;
    p = (a * b) >>> FRAC_W;
    return sat_q(p);
  endfunction

  function automatic drive_result_t step_pid(input pid_item_t it);
    int            slot;
    longint        err;
    longint        integ;
    longint        diff;
    longint        deriv;
    longint        total;
    drive_result_t r;
    slot  = it.channel % CHANNELS_DEF;
    err   = longint'(sat_q(longint'(it.target) - longint'(it.measured)));
    integ = longint'(sat_q(longint'(integral_mem[slot]) +
                           longint'(q_mul(err, longint'(dt_reg)))));
    diff  = longint'(sat_q(err - longint'(last_error_mem[slot])));
    deriv = longint'(q_mul(diff, longint'(inv_dt_reg)));
    total = longint'(q_mul(longint'(it.gain_p), err)) +
            longint'(q_mul(longint'(it.gain_i), integ)) +
            longint'(q_mul(longint'(it.gain_d), deriv));
    integral_mem[slot]   = integ[Q_W-1:0];
    last_error_mem[slot] = err[Q_W-1:0];
    r.channel = it.channel;
    r.drive   = sat_q(total);
    return r;
  endfunction

  function automatic pid_item_t make_item(input logic [CHAN_W-1:0] ch,
                                          input logic signed [Q_W-1:0] t,
                                          input logic signed [Q_W-1:0] m,
                                          input logic signed [Q_W-1:0] p,
                                          input logic signed [Q_W-1:0] i,
                                          input logic signed [Q_W-1:0] d);
    pid_item_t it;
    it.channel  = ch;
    it.target   = t;
    it.measured = m;
    it.gain_p   = p;
    it.gain_i   = i;
    it.gain_d   = d;
    return it;
  endfunction

  function automatic logic signed [Q_W-1:0] rand_extreme();
    case ($urandom_range(4))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // Mostly values within +-16.0 so the arithmetic does not just saturate.
  function automatic logic signed [Q_W-1:0] rand_value();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return rand_extreme();
      3:       return int'($urandom_range(33554432)) - 16777216;
      default: return int'($urandom_range(2097152)) - 1048576;
    endcase
  endfunction

  function automatic logic signed [Q_W-1:0] rand_gain();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return rand_extreme();
      default: return int'($urandom_range(524288)) - 262144;
    endcase
  endfunction

  // Leaves valid high after the beat so back-to-back items follow without dropping valid in between.
  task automatic send_item(input pid_item_t it);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 11) gap++;
    end
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.channel  <= it.channel;
    in_bus.target   <= it.target;
    in_bus.measured <= it.measured;
    in_bus.gain_p   <= it.gain_p;
    in_bus.gain_i   <= it.gain_i;
    in_bus.gain_d   <= it.gain_d;
    do @(posedge clk); while (!in_bus.ready);
    drive_queue.push_back(step_pid(it));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_TIME_STEP) begin
      dt_reg = data[TS_W-1:0];
    end else if (idx == REG_INV_TIME_STEP) begin
      inv_dt_reg = data[ITS_W-1:0];
    end
    @(posedge clk);
  endtask

  task automatic wait_for_drive_results();
    in_bus.valid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_registers();
    send_item(make_item(0, Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE));
    send_item(make_item(0, 2 * Q_ONE, Q_HALF, Q_HALF, -(Q_ONE / 4), 2 * Q_ONE));
    send_item(make_item(7, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
    send_item(make_item(7, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
    send_item(make_item(3, 0, 0, 0, 0, 0));
    // One-LSB products round toward minus infinity.
    send_item(make_item(5, -32'sd1, 0, 32'sd1, -32'sd1, 32'sd3));
    wait_for_drive_results();
  endtask

  task automatic test_saturation();
    write_reg(REG_TIME_STEP, 32'd65536);
    write_reg(REG_INV_TIME_STEP, 32'h7FFF_FFFF);
    // Repeated full-scale errors push the integral into saturation.
    repeat (3) send_item(make_item(1, Q_MAX, 0, Q_ONE, Q_ONE, Q_ONE));
    send_item(make_item(1, Q_MIN, 0, Q_ONE, Q_ONE, Q_ONE));
    send_item(make_item(2, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN));
    send_item(make_item(6, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX));
    wait_for_drive_results();
  endtask

  task automatic test_register_edges();
    write_reg(REG_TIME_STEP, 32'd0);
    write_reg(REG_INV_TIME_STEP, 32'd0);
    // Writes to indexes beyond the register list must leave both alone.
    write_reg(REG_INV_TIME_STEP + 8'd1, 32'h0000_1234);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    send_item(make_item(4, Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE));
    send_item(make_item(4, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    wait_for_drive_results();
    // Upper data bits beyond each register's width are dropped.
    write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(REG_INV_TIME_STEP, 32'hFFFF_FFFF);
    send_item(make_item(6, 3 * Q_ONE, 0, Q_HALF, Q_HALF, Q_HALF));
    send_item(make_item(6, -Q_HALF, Q_ONE, Q_ONE, -Q_ONE, Q_ONE));
    wait_for_drive_results();
    write_reg(REG_TIME_STEP, 32'd1);
    write_reg(REG_INV_TIME_STEP, 32'd1);
    send_item(make_item(0, Q_MAX, 0, Q_ONE, Q_MAX, Q_MAX));
    send_item(make_item(7, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    wait_for_drive_results();
  endtask

  task automatic test_random_traffic();
    int              ch;
    logic [TS_W-1:0] dt;
    longint          inv;
    ch = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        dt  = TS_RESET;
        inv = ITS_RESET;
      end else begin
        case ($urandom_range(3))
          0:       dt = 17'd1;
          1:       dt = 17'd65536;
          2:       dt = TS_W'($urandom_range(65536, 1));
          default: dt = TS_W'($urandom_range(13107, 1));
        endcase
        case ($urandom_range(3))
          0: inv = 1;
          1: inv = 2147483647;
          2: inv = longint'($urandom_range(2147483647, 1));
          default: begin
            inv = (64'sd1 << 32) / dt;
            if (inv > 2147483647) inv = 2147483647;
          end
        endcase
      end
      write_reg(REG_TIME_STEP, CFG_DATA_W'(dt));
      write_reg(REG_INV_TIME_STEP, inv[CFG_DATA_W-1:0]);
      steady = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Half the beats stay on the previous channel so its state builds up.
        if ($urandom_range(1) == 1) ch = $urandom_range(CHANNELS_DEF - 1);
        send_item(make_item(CHAN_W'(ch), rand_value(), rand_value(),
                            rand_gain(), rand_gain(), rand_gain()));
      end
      wait_for_drive_results();
      steady = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    out_bus.ready <= steady || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin : check_drive
    drive_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (drive_queue.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, actual channel %0d drive %0d",
                 $time, out_bus.out_channel, out_bus.drive);
      end else begin
        want = drive_queue.pop_front();
        if (out_bus.out_channel !== want.channel) begin
          mismatch_count++;
          $display("%0t: out_channel expected %0d actual %0d",
                   $time, want.channel, out_bus.out_channel);
        end
        if (out_bus.drive !== want.drive) begin
          mismatch_count++;
          $display("%0t: drive expected %0d actual %0d", $time, want.drive, out_bus.drive);
        end
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.channel   <= '0;
    in_bus.target    <= '0;
    in_bus.measured  <= '0;
    in_bus.gain_p    <= '0;
    in_bus.gain_i    <= '0;
    in_bus.gain_d    <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= '0;
    cfg_bus.data     <= '0;
    dt_reg     = TS_RESET;
    inv_dt_reg = ITS_RESET;
    foreach (integral_mem[k]) begin
      integral_mem[k]   = '0;
      last_error_mem[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_registers();
    test_saturation();
    test_register_edges();
    test_random_traffic();
    if (mismatch_count == 0 && drive_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mps_pkg.sv
rtl/mps_if.sv
rtl/mps_mac.sv
rtl/mps_state_mem.sv
rtl/mps_seq.sv
rtl/multichannel_pid_step_top.sv
rtl/mps_checker.sv
tb/sv/multichannel_pid_step_top_test.sv
